// ===== src/tric_pkg.sv =====
// Shared types and constants for the traceroute ICMP reply classifier.
`timescale 1ns / 1ps
`default_nettype none

package tric_pkg;

  localparam logic [7:0]  ICMP_HDR_LEN       = 8'd8;
  localparam logic [7:0]  ERR_MIN_LEN        = 8'd36;
  localparam logic [7:0]  INNER_PROTO_OFFSET = 8'd9;
  localparam logic [7:0]  UDP_PORTS_LEN      = 8'd4;
  localparam logic [7:0]  PROTO_UDP          = 8'd17;
  localparam logic [7:0]  TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0]  TYPE_UNREACHABLE   = 8'd3;
  localparam logic [7:0]  CODE_TTL_IN_TRANSIT = 8'd0;
  localparam logic [7:0]  CODE_PORT_UNREACH  = 8'd3;
  localparam logic [15:0] POS_MAX            = 16'hFFFF;
  localparam logic [15:0] BASE_DEST_PORT_RESET = 16'd33434;

  localparam logic CFG_SOURCE_PORT    = 1'b0;
  localparam logic CFG_BASE_DEST_PORT = 1'b1;

  typedef enum logic [1:0] {
    CLASS_ROUTER    = 2'd0,
    CLASS_REACHED   = 2'd1,
    CLASS_UNREACH   = 2'd2,
    CLASS_MALFORMED = 2'd3
  } reply_class_t;

  typedef struct packed {
    logic [15:0] count;
    logic [5:0]  outer_hl;
    logic [7:0]  udp_at;
    logic [7:0]  reply_type;
    logic [7:0]  reply_code;
    logic [7:0]  inner_protocol;
    logic [15:0] inner_src_port;
    logic [15:0] inner_dst_port;
    logic [15:0] expected_port;
  } fields_t;

  typedef struct packed {
    logic         hit;
    reply_class_t cls;
    logic [7:0]   code;
  } result_t;

endpackage

`default_nettype wire

// ===== src/tric_parse.sv =====
// Byte position tracking and header field capture for one packet.
`timescale 1ns / 1ps
`default_nettype none

module tric_parse
  import tric_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] probe_seq,
  input  wire logic [15:0] base_dest_port,
  output fields_t          fields
);

  logic [15:0] byte_position;
  logic [5:0]  outer_header_length;
  logic [5:0]  inner_header_length;
  logic [7:0]  reply_type;
  logic [7:0]  reply_code;
  logic [7:0]  inner_protocol;
  logic [15:0] inner_src_port;
  logic [15:0] inner_dst_port;
  logic [15:0] expected_port;

  logic [5:0]  inner_header_length_next;
  logic [16:0] pos;
  logic [16:0] h1_17;
  logic [16:0] udp_17;
  logic        first;

  always_comb begin
    first = (byte_position == 16'd0);
    pos   = {1'b0, byte_position};
    fields = '0;
    inner_header_length_next = first ? 6'd0 : inner_header_length;
    if (first) begin
      fields.outer_hl      = {data_byte[3:0], 2'b00};
      fields.expected_port = base_dest_port + probe_seq;
    end else begin
      fields.outer_hl       = outer_header_length;
      fields.expected_port  = expected_port;
      fields.reply_type     = reply_type;
      fields.reply_code     = reply_code;
      fields.inner_protocol = inner_protocol;
      fields.inner_src_port = inner_src_port;
      fields.inner_dst_port = inner_dst_port;
    end
    h1_17 = {11'd0, fields.outer_hl};
    if (pos == h1_17) fields.reply_type = data_byte;
    if (pos == h1_17 + 17'd1) fields.reply_code = data_byte;
    if (pos == h1_17 + {9'd0, ICMP_HDR_LEN})
      inner_header_length_next = {data_byte[3:0], 2'b00};
    if (pos == h1_17 + {9'd0, ICMP_HDR_LEN} + {9'd0, INNER_PROTO_OFFSET})
      fields.inner_protocol = data_byte;
    fields.udp_at = {2'b00, fields.outer_hl} + ICMP_HDR_LEN
                    + {2'b00, inner_header_length_next};
    udp_17 = {9'd0, fields.udp_at};
    if (pos == udp_17)          fields.inner_src_port[15:8] = data_byte;
    if (pos == udp_17 + 17'd1)  fields.inner_src_port[7:0]  = data_byte;
    if (pos == udp_17 + 17'd2)  fields.inner_dst_port[15:8] = data_byte;
    if (pos == udp_17 + 17'd3)  fields.inner_dst_port[7:0]  = data_byte;
    fields.count = (byte_position == POS_MAX) ? POS_MAX : byte_position + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
    end else if (accept) begin
      byte_position <= last_byte ? 16'd0 : fields.count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      outer_header_length <= fields.outer_hl;
      inner_header_length <= inner_header_length_next;
      reply_type          <= fields.reply_type;
      reply_code          <= fields.reply_code;
      inner_protocol      <= fields.inner_protocol;
      inner_src_port      <= fields.inner_src_port;
      inner_dst_port      <= fields.inner_dst_port;
      expected_port       <= fields.expected_port;
    end
  end

endmodule

`default_nettype wire

// ===== src/tric_classify.sv =====
// End-of-packet reply classification from the captured header fields.
`timescale 1ns / 1ps
`default_nettype none

module tric_classify
  import tric_pkg::*;
(
  input  wire fields_t     fields,
  input  wire logic [15:0] source_port,
  output result_t          result
);

  logic [16:0] count17;
  logic [16:0] h1_17;
  logic        is_tx;
  logic        is_un;
  logic        match;

  always_comb begin
    count17 = {1'b0, fields.count};
    h1_17   = {11'd0, fields.outer_hl};
    is_tx   = (fields.reply_type == TYPE_TIME_EXCEEDED) &&
              (fields.reply_code == CODE_TTL_IN_TRANSIT);
    is_un   = (fields.reply_type == TYPE_UNREACHABLE);
    match   = (fields.inner_protocol == PROTO_UDP) &&
              (count17 >= {9'd0, fields.udp_at} + {9'd0, UDP_PORTS_LEN}) &&
              (fields.inner_src_port == source_port) &&
              (fields.inner_dst_port == fields.expected_port);
    result = '{hit: 1'b0, cls: CLASS_MALFORMED, code: 8'd0};
    priority if (count17 < h1_17 + {9'd0, ICMP_HDR_LEN}) begin
      result.hit = 1'b1;
    end else if (!is_tx && !is_un) begin
      result.hit = 1'b0;
    end else if (count17 < h1_17 + {9'd0, ERR_MIN_LEN}) begin
      result.hit = 1'b1;
    end else if (match) begin
      result.hit  = 1'b1;
      result.code = fields.reply_code;
      priority if (is_tx) begin
        result.cls = CLASS_ROUTER;
      end else if (fields.reply_code == CODE_PORT_UNREACH) begin
        result.cls = CLASS_REACHED;
      end else begin
        result.cls = CLASS_UNREACH;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tric_out_buf.sv =====
// Output register with a skid stage for result beats.
`timescale 1ns / 1ps
`default_nettype none

module tric_out_buf
  import tric_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    advance;

  assign full    = skid_valid;
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/traceroute_icmp_reply_classifier_unit.sv =====
// Top level of the traceroute ICMP reply classifier.
//
// Input channel: one packet byte per beat (data_byte, last_byte, probe_seq)
// under in_valid / in_stall. probe_seq is sampled on the first byte.
// Output channel: one beat (reply_class, icmp_code_out) under out_valid /
// out_stall, only for packets that classify; other packets give nothing.
// Configuration: cfg_write with cfg_index 0 sets source_port, index 1 sets
// base_dest_port; write only while no packet is in progress.
// Throughput: one byte per cycle while in_stall is low, with the field capture
// and classify logic combinational in front of the result register.
// A result enters the output register, or the skid entry under out_stall.
// Stall: a two-entry output buffer absorbs results while out_stall is high;
// in_stall rises only when both entries hold results.
// Reset (rst, synchronous): empties the output buffer, restarts the byte
// position, and sets source_port to 0 and base_dest_port to 33434.
`timescale 1ns / 1ps
`default_nettype none

module traceroute_icmp_reply_classifier_unit
  import tric_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] probe_seq,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       reply_class,
  output logic [7:0]       icmp_code_out,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] source_port;
  logic [15:0] base_dest_port;
  logic        accept;
  fields_t     fields;
  result_t     result;
  result_t     out_data;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_port    <= 16'd0;
      base_dest_port <= BASE_DEST_PORT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SOURCE_PORT:    source_port    <= cfg_data;
        CFG_BASE_DEST_PORT: base_dest_port <= cfg_data;
        default:            source_port    <= source_port;
      endcase
    end
  end

  tric_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .probe_seq      (probe_seq),
    .base_dest_port (base_dest_port),
    .fields         (fields)
  );

  tric_classify u_classify (
    .fields      (fields),
    .source_port (source_port),
    .result      (result)
  );

  tric_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && last_byte && result.hit),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign reply_class   = out_data.cls;
  assign icmp_code_out = out_data.code;

endmodule

`default_nettype wire
